/* hdl/frhp_pkg.sv */
// ----------------------------------------------------------------------------
// frhp_pkg
// Shared types, constants and rounding helper for the pi/2 reduction pipeline.
// ----------------------------------------------------------------------------
package frhp_pkg;

   localparam logic [415:0] TWO_OVER_PI = {
      32'ha2f9836e, 32'h4e441529, 32'hfc2757d1,
      32'hf534ddc0, 32'hdb629599, 32'h3c439041,
      32'hfe5163ab, 32'hdebbc561, 32'hb7246e3a,
      32'h424dd2e0, 32'h06492eea, 32'h09d1921c,
      32'hfe1deb1c
   };

   localparam logic [23:0] HALF_PI_HI_MANT = 24'hc90fdb;
   localparam logic [23:0] HALF_PI_LO_MANT = 24'hbbbd2e;
   localparam logic [7:0]  WINDOW_EXP_MIN  = 8'd72;
   localparam logic [23:0] MANT_ONE        = 24'h800000;

   typedef struct packed {
      logic        neg;
      logic [1:0]  quad;
      logic [45:0] frac;
   } fix_type;

   typedef struct packed {
      logic               neg;
      logic               zero;
      logic [1:0]         quad;
      logic [23:0]        mant;
      logic signed [9:0]  expo;
   } flt_type;

   function automatic logic [24:0] rne24(input logic [23:0] m, input logic r,
                                         input logic s);
      logic inc;
      inc = r & (s | m[0]);
      return {1'b0, m} + {24'd0, inc};
   endfunction

endpackage

/* hdl/frhp_fixmul.sv */
// ----------------------------------------------------------------------------
// frhp_fixmul
// Four-stage fixed-point product of the significand with a 2/pi window,
// folded to quadrant and a 46-bit fraction of at most one half.
// ----------------------------------------------------------------------------
module frhp_fixmul (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  logic [31:0]       x_bits,
   output logic              out_valid,
   output frhp_pkg::fix_type out_data
);

   logic         v1_ff, v2_ff, v3_ff, v4_ff;
   logic         xs1_ff, xs2_ff, xs3_ff;
   logic [79:0]  win_in, win_ff;
   logic [23:0]  mant_in, mant_ff;
   logic [575:0] padded, shifted;
   logic [7:0]   amt;

   logic [23:0]  p_hd1_ff, p_hd2_ff, p_hd3_ff, p_hd4_ff;
   logic [31:0]  p_ld0_ff, p_ld1_ff, p_ld2_ff, p_ld3_ff;
   logic [47:0]  t_in, t_ff;
   logic         flip;
   frhp_pkg::fix_type res_in, res_ff;

   assign amt     = x_bits[30:23] - frhp_pkg::WINDOW_EXP_MIN;
   assign padded  = {80'd0, frhp_pkg::TWO_OVER_PI, 80'd0};
   assign shifted = padded << amt;
   assign win_in  = (x_bits[30:23] < frhp_pkg::WINDOW_EXP_MIN) ? 80'd0 : shifted[575:496];
   assign mant_in = {1'b1, x_bits[22:0]};

   assign t_in = (48'(p_hd1_ff) << 32) + (48'(p_ld0_ff) << 32)
               + (48'(p_hd2_ff) << 16) + (48'(p_ld1_ff) << 16)
               + 48'(p_hd3_ff) + 48'(p_ld2_ff)
               + 48'(p_hd4_ff[23:16]) + 48'(p_ld3_ff[31:16]);

   // fold a fraction of one half or more to its complement
   assign flip        = t_ff[45];
   assign res_in.frac = flip ? (46'd0 - t_ff[45:0]) : t_ff[45:0];
   assign res_in.neg  = flip ^ xs3_ff;
   assign res_in.quad = xs3_ff ? (2'd0 - (t_ff[47:46] + {1'b0, flip}))
                               : (t_ff[47:46] + {1'b0, flip});

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      win_ff   <= win_in;
      mant_ff  <= mant_in;
      xs1_ff   <= x_bits[31];
      p_hd1_ff <= mant_ff[23:16] * win_ff[63:48];
      p_ld0_ff <= mant_ff[15:0]  * win_ff[79:64];
      p_hd2_ff <= mant_ff[23:16] * win_ff[47:32];
      p_ld1_ff <= mant_ff[15:0]  * win_ff[63:48];
      p_hd3_ff <= mant_ff[23:16] * win_ff[31:16];
      p_ld2_ff <= mant_ff[15:0]  * win_ff[47:32];
      p_hd4_ff <= mant_ff[23:16] * win_ff[15:0];
      p_ld3_ff <= mant_ff[15:0]  * win_ff[31:16];
      xs2_ff   <= xs1_ff;
      t_ff     <= t_in;
      xs3_ff   <= xs2_ff;
      res_ff   <= res_in;
   end

   assign out_valid = v4_ff;
   assign out_data  = res_ff;

endmodule

/* hdl/frhp_tofloat.sv */
// ----------------------------------------------------------------------------
// frhp_tofloat
// Three-stage conversion of the 46-bit fraction to a rounded 24-bit
// significand: round the low 30 bits to single precision and add them back
// to the high part, leading-zero count, then shift and round to nearest even.
// ----------------------------------------------------------------------------
module frhp_tofloat (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  frhp_pkg::fix_type in_data,
   output logic              out_valid,
   output frhp_pkg::flt_type out_data
);

   logic              v1_ff, v2_ff, v3_ff;
   logic [30:0]       lo_rnd;
   frhp_pkg::fix_type pre_in, pre_ff;
   logic [5:0]        lz_in, lz_ff;
   frhp_pkg::fix_type fix_ff;
   logic [45:0]       norm;
   logic [24:0]       rnd;
   frhp_pkg::flt_type res_in, res_ff;

   // round the low 30 bits to 24 significant bits on their own
   always_comb begin
      lo_rnd = {1'b0, in_data.frac[29:0]};
      for (int k = 1; k < 7; k++) begin
         if (in_data.frac[k + 23]) begin
            lo_rnd = (({1'b0, in_data.frac[29:0]} >> k)
                   + {30'd0, in_data.frac[k - 1]
                     & (in_data.frac[k]
                        | (|(in_data.frac[29:0] & ((30'd1 << (k - 1)) - 30'd1))))})
                   << k;
         end
      end
   end

   assign pre_in.neg  = in_data.neg;
   assign pre_in.quad = in_data.quad;
   assign pre_in.frac = {in_data.frac[45:30], 30'd0} + {15'd0, lo_rnd};

   always_comb begin
      lz_in = 6'd0;
      for (int i = 0; i < 46; i++) begin
         if (pre_ff.frac[i]) begin
            lz_in = 6'(45 - i);
         end
      end
   end

   assign norm        = fix_ff.frac << lz_ff;
   assign rnd         = frhp_pkg::rne24(norm[45:22], norm[21], |norm[20:0]);
   assign res_in.neg  = fix_ff.neg;
   assign res_in.zero = (fix_ff.frac == 46'd0);
   assign res_in.quad = fix_ff.quad;
   assign res_in.mant = rnd[24] ? frhp_pkg::MANT_ONE : rnd[23:0];
   assign res_in.expo = -10'sd24 - $signed({4'd0, lz_ff}) + $signed({9'd0, rnd[24]});

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      pre_ff <= pre_in;
      fix_ff <= pre_ff;
      lz_ff  <= lz_in;
      res_ff <= res_in;
   end

   assign out_valid = v3_ff;
   assign out_data  = res_ff;

endmodule

/* hdl/frhp_pimul.sv */
// ----------------------------------------------------------------------------
// frhp_pimul
// Four-stage scale by the two-part pi/2: both products, their rounding,
// exact difference, then normalize, round and pack to single precision.
// ----------------------------------------------------------------------------
module frhp_pimul (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  frhp_pkg::flt_type in_data,
   output logic              out_valid,
   output logic [31:0]       out_bits,
   output logic [1:0]        out_quad
);

   function automatic logic [25:0] round_prod(input logic [47:0] p);
      logic [24:0] r;
      logic [1:0]  k;
      if (p[47]) begin
         r = frhp_pkg::rne24(p[47:24], p[23], |p[22:0]);
      end else begin
         r = frhp_pkg::rne24(p[46:23], p[22], |p[21:0]);
      end
      k = {1'b0, p[47]} + {1'b0, r[24]};
      return {k, (r[24] ? frhp_pkg::MANT_ONE : r[23:0])};
   endfunction

   logic              v1_ff, v2_ff, v3_ff, v4_ff;
   frhp_pkg::flt_type f1_ff, f2_ff, f3_ff;
   logic [47:0]       ph_ff, pl_ff;
   logic [25:0]       rh, rl;
   logic [23:0]       pm_ff, qm_ff;
   logic [1:0]        ka_ff, kb_ff;
   logic              d26;
   logic [50:0]       diff_in, diff_ff;
   logic signed [9:0] b_in, b_ff;
   logic [1:0]        sh;
   logic [50:0]       g;
   logic [24:0]       rnd;
   logic signed [9:0] bexp;
   logic [31:0]       bits_in, bits_ff;
   logic [1:0]        quad_ff;

   assign rh = round_prod(ph_ff);
   assign rl = round_prod(pl_ff);

   assign d26     = (ka_ff == kb_ff + 2'd1);
   assign diff_in = (d26 ? (51'(pm_ff) << 26) : (51'(pm_ff) << 25)) - 51'(qm_ff);
   assign b_in    = f2_ff.expo - 10'sd25 + $signed({8'd0, kb_ff});

   always_comb begin
      priority if (diff_ff[49]) begin
         sh = 2'd0;
      end else if (diff_ff[48]) begin
         sh = 2'd1;
      end else begin
         sh = 2'd2;
      end
   end

   assign g       = diff_ff << sh;
   assign rnd     = frhp_pkg::rne24(g[49:26], g[25], |g[24:0]);
   assign bexp    = b_ff + 10'sd176 - $signed({8'd0, sh}) + $signed({9'd0, rnd[24]});
   assign bits_in = f3_ff.zero ? 32'd0
                  : {f3_ff.neg, bexp[7:0], (rnd[24] ? 23'd0 : rnd[22:0])};

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      f1_ff   <= in_data;
      ph_ff   <= in_data.mant * frhp_pkg::HALF_PI_HI_MANT;
      pl_ff   <= in_data.mant * frhp_pkg::HALF_PI_LO_MANT;
      f2_ff   <= f1_ff;
      pm_ff   <= rh[23:0];
      qm_ff   <= rl[23:0];
      ka_ff   <= rh[25:24];
      kb_ff   <= rl[25:24];
      f3_ff   <= f2_ff;
      diff_ff <= diff_in;
      b_ff    <= b_in;
      bits_ff <= bits_in;
      quad_ff <= f3_ff.quad;
   end

   assign out_valid = v4_ff;
   assign out_bits  = bits_ff;
   assign out_quad  = quad_ff;

endmodule

/* hdl/float_reduce_by_half_pi.sv */
// ----------------------------------------------------------------------------
// float_reduce_by_half_pi
// Single-precision reduction by pi/2: quadrant and remainder in +-pi/4.
// ----------------------------------------------------------------------------
// Each accepted item passes through frhp_fixmul, frhp_tofloat and frhp_pimul in order.
// Throughput: one item per cycle; eleven stages, each holding one item.
// busy is high only while reset is high; the receiver cannot stall.
// Reset clears all stage valid bits; data registers are not reset.
module float_reduce_by_half_pi (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [31:0] req_x_bits,
   output logic        rsp_valid,
   output logic [31:0] rsp_remainder_bits,
   output logic [1:0]  rsp_quadrant
);

   logic              accept;
   logic              fix_valid, flt_valid;
   frhp_pkg::fix_type fix_data;
   frhp_pkg::flt_type flt_data;

   assign busy   = reset;
   assign accept = start & ~busy;

   frhp_fixmul u_fixmul (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (accept),
      .x_bits    (req_x_bits),
      .out_valid (fix_valid),
      .out_data  (fix_data)
   );

   frhp_tofloat u_tofloat (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (fix_valid),
      .in_data   (fix_data),
      .out_valid (flt_valid),
      .out_data  (flt_data)
   );

   frhp_pimul u_pimul (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (flt_valid),
      .in_data   (flt_data),
      .out_valid (rsp_valid),
      .out_bits  (rsp_remainder_bits),
      .out_quad  (rsp_quadrant)
   );

endmodule

/* hdl/frhp_check.sv */
// ----------------------------------------------------------------------------
// frhp_check
// Port-level checks for the pi/2 reduction pipeline, bound to the top level.
// ----------------------------------------------------------------------------
module frhp_check (
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input logic [31:0] req_x_bits,
   input logic        rsp_valid,
   input logic [31:0] rsp_remainder_bits,
   input logic [1:0]  rsp_quadrant
);

   a_accept_to_rsp: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##11 rsp_valid)
      else $error("accepted item produced no result");

   a_rsp_from_accept: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, 11))
      else $error("result without an accepted item");

   a_zero_positive: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_remainder_bits[30:0] == 31'd0) |-> !rsp_remainder_bits[31])
      else $error("zero remainder carries a sign");

   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_remainder_bits[30:23] <= 8'd126))
      else $error("remainder out of range");

endmodule

bind float_reduce_by_half_pi frhp_check u_check (.*);

/* verif/tb_float_reduce_by_half_pi.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_float_reduce_by_half_pi
// Drives single-precision values into the pi/2 reduction pipeline and checks
// every quadrant and remainder against a table entry or a bit-exact integer
// model of the window multiply, fold and single-precision rounding steps. A
// directed table comes first, then random values under three sender idling mixes.
// ----------------------------------------------------------------------------
module tb_float_reduce_by_half_pi;

   typedef struct packed {
      logic [31:0] rem;
      logic [1:0]  quad;
   } reduced_type;

   typedef struct packed {
      logic [31:0] x;
      logic        typed;
      logic [31:0] rem;
      logic [1:0]  quad;
   } stim_row_type;

   localparam logic [31:0] OVER_PI_WORDS [13] = '{
      32'ha2f9836e, 32'h4e441529, 32'hfc2757d1,
      32'hf534ddc0, 32'hdb629599, 32'h3c439041,
      32'hfe5163ab, 32'hdebbc561, 32'hb7246e3a,
      32'h424dd2e0, 32'h06492eea, 32'h09d1921c,
      32'hfe1deb1c
   };
   localparam logic [23:0] PIO2_HI_MANT = 24'hc90fdb;
   localparam int          PIO2_HI_EXP  = -23;
   localparam logic [23:0] PIO2_LO_MANT = 24'hbbbd2e;
   localparam int          PIO2_LO_EXP  = -48;
   localparam int          N_RANDOM     = 680;
   localparam int          WATCHDOG_MAX = 2000;
   localparam int          DRAIN_CYCLES = 20;
   localparam int          N_DIRECTED   = 22;

   localparam stim_row_type DIRECTED [N_DIRECTED] = '{
      '{32'h00000000, 1'b1, 32'h00000000, 2'd0},
      '{32'h80000000, 1'b1, 32'h00000000, 2'd0},
      '{32'h00000001, 1'b1, 32'h00000000, 2'd0},
      '{32'h807fffff, 1'b1, 32'h00000000, 2'd0},
      '{32'h1c000000, 1'b1, 32'h00000000, 2'd0},
      '{32'h00800000, 1'b0, 32'h0, 2'd0},
      '{32'h7f800000, 1'b0, 32'h0, 2'd0},
      '{32'hff800000, 1'b0, 32'h0, 2'd0},
      '{32'h7fc00000, 1'b0, 32'h0, 2'd0},
      '{32'hffffffff, 1'b0, 32'h0, 2'd0},
      '{32'h7f7fffff, 1'b0, 32'h0, 2'd0},
      '{32'h3f800000, 1'b0, 32'h0, 2'd0},
      '{32'hbf800000, 1'b0, 32'h0, 2'd0},
      '{32'h3f490fdb, 1'b0, 32'h0, 2'd0},
      '{32'h3f490fdc, 1'b0, 32'h0, 2'd0},
      '{32'h3fc90fdb, 1'b0, 32'h0, 2'd0},
      '{32'h40490fdb, 1'b0, 32'h0, 2'd0},
      '{32'hc0490fdb, 1'b0, 32'h0, 2'd0},
      '{32'h4b000000, 1'b0, 32'h0, 2'd0},
      '{32'h5d000000, 1'b0, 32'h0, 2'd0},
      '{32'h3effffff, 1'b0, 32'h0, 2'd0},
      '{32'h78aaaaaa, 1'b0, 32'h0, 2'd0}
   };

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [31:0] req_x_bits = 32'd0;
   logic        rsp_valid;
   logic [31:0] rsp_remainder_bits;
   logic [1:0]  rsp_quadrant;

   reduced_type  expected_q [$];
   stim_row_type typed_q [$];
   int           mismatches = 0;
   int           idle_pct = 0;
   int           stall_count = 0;

   float_reduce_by_half_pi i_dut (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_x_bits         (req_x_bits),
      .rsp_valid          (rsp_valid),
      .rsp_remainder_bits (rsp_remainder_bits),
      .rsp_quadrant       (rsp_quadrant)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic [31:0] over_pi_slice(int pos);
      int          idx;
      int          sh;
      logic [31:0] top;
      logic [31:0] bot;
      if (pos < 0) begin
         if (pos <= -32) return 32'd0;
         return OVER_PI_WORDS[0] >> (-pos);
      end
      idx = pos >> 5;
      sh  = pos & 31;
      top = (idx < 13) ? OVER_PI_WORDS[idx] : 32'd0;
      bot = (idx + 1 < 13) ? OVER_PI_WORDS[idx + 1] : 32'd0;
      if (sh == 0) return top;
      return (top << sh) | (bot >> (32 - sh));
   endfunction

   // round mag * 2^e to single precision, nearest even; no subnormals arise
   function automatic logic [31:0] round_single(logic sgn, logic [95:0] mag, int e);
      int          p;
      int          sh;
      logic [95:0] keep;
      logic [95:0] mask;
      logic        guard;
      logic        sticky;
      if (mag == 96'd0) return {sgn, 31'd0};
      p = 0;
      for (int i = 0; i < 96; i++) if (mag[i]) p = i;
      sh = p - 23;
      if (sh > 0) begin
         keep   = mag >> sh;
         guard  = mag[sh - 1];
         mask   = (96'd1 << (sh - 1)) - 96'd1;
         sticky = |(mag & mask);
         if (guard && (sticky || keep[0])) keep = keep + 96'd1;
         if (keep[24]) begin
            keep = keep >> 1;
            sh++;
         end
      end else begin
         keep = mag << (-sh);
      end
      return {sgn, 8'(e + sh + 150), keep[22:0]};
   endfunction

   function automatic logic [31:0] mul_single(logic [31:0] a, logic [23:0] m, int e,
                                              logic sgn);
      logic [95:0] prod;
      prod = 96'({1'b1, a[22:0]}) * 96'(m);
      return round_single(a[31] ^ sgn, prod, int'(a[30:23]) - 150 + e);
   endfunction

   function automatic logic [31:0] add_single(logic [31:0] a, logic [31:0] b);
      int          ea;
      int          eb;
      int          em;
      logic [95:0] ma;
      logic [95:0] mb;
      ea = int'(a[30:23]) - 150;
      eb = int'(b[30:23]) - 150;
      em = (ea < eb) ? ea : eb;
      ma = 96'({1'b1, a[22:0]}) << (ea - em);
      mb = 96'({1'b1, b[22:0]}) << (eb - em);
      if (a[31] == b[31]) return round_single(a[31], ma + mb, em);
      if (ma >= mb) return round_single(a[31], ma - mb, em);
      return round_single(b[31], mb - ma, em);
   endfunction

   function automatic reduced_type reduce_by_half_pi(logic [31:0] x);
      int          pos;
      logic [31:0] mant;
      logic [31:0] s0;
      logic [31:0] s1;
      logic [31:0] s2;
      logic [31:0] mh;
      logic [31:0] ml;
      logic [31:0] d0;
      logic [31:0] d1;
      logic [31:0] d2;
      logic [31:0] d3;
      logic [31:0] d4;
      logic [31:0] c2;
      logic [31:0] c3;
      logic [31:0] c4;
      logic [31:0] t;
      logic [31:0] hi;
      logic [31:0] lo;
      logic [31:0] frac_lo;
      logic [95:0] frac_lo_rnd;
      logic [95:0] sum;
      logic [31:0] fb;
      logic [31:0] f;
      logic        flip;
      reduced_type res;
      pos  = int'(x[30:23]) - 152;
      mant = {8'd0, 1'b1, x[22:0]};
      s0 = over_pi_slice(pos);
      s1 = over_pi_slice(pos + 32);
      s2 = over_pi_slice(pos + 64);
      mh = mant >> 16;
      ml = mant & 32'hffff;
      d0 = s0 >> 16;
      d1 = s0 & 32'hffff;
      d2 = s1 >> 16;
      d3 = s1 & 32'hffff;
      d4 = s2 >> 16;
      c2 = 0;
      c3 = 0;
      c4 = 0;
      t = mh * d1; c2 += t & 32'hffff;
      t = ml * d0; c2 += t & 32'hffff;
      t = mh * d2; c2 += t >> 16; c3 += t & 32'hffff;
      t = ml * d1; c2 += t >> 16; c3 += t & 32'hffff;
      t = mh * d3; c3 += t >> 16; c4 += t & 32'hffff;
      t = ml * d2; c3 += t >> 16; c4 += t & 32'hffff;
      t = mh * d4; c4 += t >> 16;
      t = ml * d3; c4 += t >> 16;
      c3 += c4 >> 16;
      c4 &= 32'hffff;
      c2 += c3 >> 16;
      c3 &= 32'hffff;
      res.quad = c2[15:14];
      hi   = ((c2 & 32'h3fff) << 16) | c3;
      lo   = c4;
      flip = 1'b0;
      if (hi >= 32'h20000000) begin
         hi = (32'h40000000 - hi - ((lo != 0) ? 32'd1 : 32'd0)) & 32'h3fffffff;
         lo = (32'd0 - lo) & 32'hffff;
         flip = 1'b1;
         res.quad = res.quad + 2'd1;
      end
      if (x[31]) res.quad = 2'd0 - res.quad;
      frac_lo = ((hi & 32'h3fff) << 16) | lo;
      if (frac_lo < 32'h01000000) begin
         frac_lo_rnd = 96'(frac_lo);
      end else begin
         fb = round_single(1'b0, 96'(frac_lo), 0);
         frac_lo_rnd = 96'({1'b1, fb[22:0]}) << (int'(fb[30:23]) - 150);
      end
      sum = (96'(hi >> 14) << 30) + frac_lo_rnd;
      if (sum == 96'd0) begin
         res.rem = 32'd0;
      end else begin
         f = round_single(flip ^ x[31], sum, -46);
         res.rem = add_single(mul_single(f, PIO2_HI_MANT, PIO2_HI_EXP, 1'b0),
                              mul_single(f, PIO2_LO_MANT, PIO2_LO_EXP, 1'b1));
      end
      return res;
   endfunction

   always @(posedge clock) begin
      stim_row_type row;
      reduced_type  got;
      reduced_type  want;
      if (!reset && start && !busy) begin
         row = typed_q.pop_front();
         if (row.typed) expected_q.push_back({row.rem, row.quad});
         else expected_q.push_back(reduce_by_half_pi(row.x));
      end
      if (!reset && rsp_valid) begin
         got = {rsp_remainder_bits, rsp_quadrant};
         if (expected_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected item: rem=%h quad=%0d", got.rem, got.quad);
         end else begin
            want = expected_q.pop_front();
            if (got.rem !== want.rem || got.quad !== want.quad) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: rem exp %h got %h, quad exp %0d got %0d",
                           want.rem, got.rem, want.quad, got.quad);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         stall_count <= 0;
      end else if (stall_count >= WATCHDOG_MAX) begin
         $display("tb_float_reduce_by_half_pi failed");
         $finish;
      end else begin
         stall_count <= stall_count + 1;
      end
   end

   task automatic send_item(stim_row_type row);
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      typed_q.push_back(row);
      start      <= 1'b1;
      req_x_bits <= row.x;
      do @(posedge clock); while (busy);
   endtask

   task automatic drain();
      start <= 1'b0;
      @(posedge clock);
      while (expected_q.size() != 0) @(posedge clock);
   endtask

   function automatic logic [31:0] random_value();
      int sel;
      sel = $urandom_range(7);
      if (sel == 0) return $urandom;
      if (sel == 1) return {1'($urandom), 8'($urandom_range(255)), 23'($urandom)};
      return {1'($urandom), 8'($urandom_range(160, 112)), 23'($urandom)};
   endfunction

   initial begin
      stim_row_type row;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      idle_pct = 23;
      for (int i = 0; i < N_DIRECTED; i++) send_item(DIRECTED[i]);
      for (int phase = 0; phase < 3; phase++) begin
         idle_pct = (phase == 0) ? 23 : (phase == 1) ? 54 : 0;
         for (int i = 0; i < N_RANDOM / 3; i++) begin
            row = '{random_value(), 1'b0, 32'd0, 2'd0};
            send_item(row);
         end
         drain();
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0 && expected_q.size() == 0) begin
         $display("tb_float_reduce_by_half_pi passed");
      end else begin
         $display("tb_float_reduce_by_half_pi failed");
      end
      $finish;
   end

endmodule
